[src/ipv4nat_pkg.sv]
// ----------------------------------------------------------------------------
// ipv4nat_pkg
// Shared constants, result record type and one's-complement helper for the
// IPv4 address rewrite and checksum block.
// ----------------------------------------------------------------------------
package ipv4nat_pkg;

    localparam int POS_W = 12;
    localparam logic [POS_W-1:0] MAX_FRAME_BYTES = 12'd2048;

    localparam logic [7:0] PROTO_TCP = 8'h06;
    localparam logic [7:0] PROTO_UDP = 8'h11;
    localparam logic [7:0] MCAST_LO = 8'd224;
    localparam logic [7:0] MCAST_HI = 8'd239;
    localparam logic [7:0] BCAST_BYTE = 8'd255;

    localparam logic [POS_W-1:0] POS_FRAG_HI = 12'd20;
    localparam logic [POS_W-1:0] POS_FRAG_LO = 12'd21;
    localparam logic [POS_W-1:0] POS_PROTO = 12'd23;
    localparam logic [POS_W-1:0] POS_HDR_FIRST = 12'd14;
    localparam logic [POS_W-1:0] POS_IPCS_HI = 12'd24;
    localparam logic [POS_W-1:0] POS_IPCS_LO = 12'd25;
    localparam logic [POS_W-1:0] POS_SRC_FIRST = 12'd26;
    localparam logic [POS_W-1:0] POS_SRC_LAST = 12'd29;
    localparam logic [POS_W-1:0] POS_DST_FIRST = 12'd30;
    localparam logic [POS_W-1:0] POS_DST_HELD = 12'd32;
    localparam logic [POS_W-1:0] POS_DST_LAST = 12'd33;
    localparam logic [POS_W-1:0] POS_PAYLOAD = 12'd34;
    localparam logic [POS_W-1:0] POS_UDPCS_HI = 12'd40;
    localparam logic [POS_W-1:0] POS_UDPCS_LO = 12'd41;
    localparam logic [POS_W-1:0] POS_TCPCS_HI = 12'd50;
    localparam logic [POS_W-1:0] POS_TCPCS_LO = 12'd51;

    localparam int RES_MAX = 4;
    localparam int RES_CNT_W = 3;
    localparam int Q_DEPTH = 8;
    localparam int Q_AW = 3;
    localparam int Q_CNT_W = 4;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        out_last;
        logic [15:0] ip_checksum;
        logic [15:0] tcp_checksum;
        logic        tcp_present;
        logic        checksums_valid;
    } t_res;

    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

[src/ipv4nat_core.sv]
// ----------------------------------------------------------------------------
// ipv4nat_core
// Per-byte rewrite and running checksum state. Produces up to four result
// items for each accepted frame byte.
// ----------------------------------------------------------------------------
module ipv4nat_core
    import ipv4nat_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_frame_last,
    input  logic [31:0]          i_new_source,
    input  logic [31:0]          i_new_dest,
    output t_res                 o_res [RES_MAX],
    output logic [RES_CNT_W-1:0] o_cnt
);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [15:0]      r_hdr, n_hdr;
    logic [15:0]      r_seg, n_seg;
    logic [7:0]       r_proto, n_proto;
    logic [15:0]      r_frag, n_frag;
    logic [31:0]      r_src, n_src;
    logic [31:0]      r_dst, n_dst;
    logic [7:0]       r_held [3];

    logic [7:0]           v;
    logic [7:0]           b30, b31, b32, b33;
    logic [15:0]          w, w1, w2;
    logic                 keep;
    logic                 valid;
    logic [15:0]          tcp_sum;
    logic [1:0]           k_src;
    logic [1:0]           k_held;
    logic [POS_W-1:0]     len;
    logic [RES_CNT_W-1:0] cnt;
    t_res                 res [RES_MAX];

    always_comb begin
        n_pos   = r_pos;
        n_hdr   = r_hdr;
        n_seg   = r_seg;
        n_proto = r_proto;
        n_frag  = r_frag;
        n_src   = r_src;
        n_dst   = r_dst;
        cnt     = '0;
        v       = i_data_byte;
        w       = '0;
        w1      = '0;
        w2      = '0;
        b30     = '0;
        b31     = '0;
        b32     = '0;
        b33     = '0;
        keep    = 1'b0;
        k_src   = 2'(r_pos - POS_SRC_FIRST);
        k_held  = 2'(r_pos - POS_DST_FIRST);
        len     = r_pos - (POS_PAYLOAD - 12'd1);
        for (int k = 0; k < RES_MAX; k++) begin
            res[k] = '0;
        end

        if (r_pos == '0) begin
            n_src   = i_new_source;
            n_dst   = i_new_dest;
            n_hdr   = '0;
            n_seg   = '0;
            n_proto = '0;
            n_frag  = '0;
        end

        if (r_pos >= POS_SRC_FIRST && r_pos <= POS_SRC_LAST) begin
            case (k_src)
                2'd0: v = r_src[31:24];
                2'd1: v = r_src[23:16];
                2'd2: v = r_src[15:8];
                default: v = r_src[7:0];
            endcase
            w = r_pos[0] ? {8'h00, v} : {v, 8'h00};
            n_hdr = oc_add(r_hdr, w);
            n_seg = oc_add(r_seg, w);
            res[0].out_byte = v;
            cnt = 3'd1;
        end else if (r_pos >= POS_DST_FIRST && r_pos <= POS_DST_HELD) begin
            // short frame: flush held bytes unchanged
            if (i_frame_last) begin
                for (int k = 0; k < 3; k++) begin
                    res[k].out_byte = (2'(k) == k_held) ? i_data_byte : r_held[k];
                end
                cnt = RES_CNT_W'(r_pos - (POS_DST_FIRST - 12'd1));
            end
        end else if (r_pos == POS_DST_LAST) begin
            keep = (r_held[0] >= MCAST_LO && r_held[0] <= MCAST_HI)
                || i_data_byte == BCAST_BYTE;
            b30 = keep ? r_held[0] : r_dst[31:24];
            b31 = keep ? r_held[1] : r_dst[23:16];
            b32 = keep ? r_held[2] : r_dst[15:8];
            b33 = keep ? i_data_byte : r_dst[7:0];
            w1 = {b30, b31};
            w2 = {b32, b33};
            n_hdr = oc_add(oc_add(r_hdr, w1), w2);
            n_seg = oc_add(oc_add(r_seg, w1), w2);
            res[0].out_byte = b30;
            res[1].out_byte = b31;
            res[2].out_byte = b32;
            res[3].out_byte = b33;
            cnt = 3'd4;
        end else begin
            if (r_pos == POS_FRAG_HI) n_frag[15:8] = i_data_byte;
            if (r_pos == POS_FRAG_LO) n_frag[7:0] = i_data_byte;
            if (r_pos == POS_PROTO) n_proto = i_data_byte;
            if (r_pos == POS_IPCS_HI || r_pos == POS_IPCS_LO) v = '0;
            if (r_proto == PROTO_TCP && (r_pos == POS_TCPCS_HI || r_pos == POS_TCPCS_LO)) begin
                v = '0;
            end else if (r_proto == PROTO_UDP && r_frag[7:0] == 8'h00 && !r_frag[8]
                         && (r_pos == POS_UDPCS_HI || r_pos == POS_UDPCS_LO)) begin
                v = '0;
            end
            w = r_pos[0] ? {8'h00, v} : {v, 8'h00};
            if (r_pos >= POS_HDR_FIRST && r_pos <= POS_IPCS_LO) begin
                n_hdr = oc_add(r_hdr, w);
            end else if (r_pos >= POS_PAYLOAD && r_pos < MAX_FRAME_BYTES) begin
                n_seg = oc_add(r_seg, w);
            end
            res[0].out_byte = v;
            cnt = 3'd1;
        end

        valid   = (r_pos >= POS_DST_LAST) && (r_pos < MAX_FRAME_BYTES);
        tcp_sum = oc_add(oc_add(n_seg, {8'h00, n_proto}), {4'h0, len});

        if (i_frame_last) begin
            for (int k = 0; k < RES_MAX; k++) begin
                if (RES_CNT_W'(k) == cnt - 3'd1) begin
                    res[k].out_last        = 1'b1;
                    res[k].tcp_present     = (n_proto == PROTO_TCP);
                    res[k].checksums_valid = valid;
                    res[k].ip_checksum     = valid ? ~n_hdr : 16'h0000;
                    res[k].tcp_checksum    = (valid && n_proto == PROTO_TCP)
                                           ? ~tcp_sum : 16'h0000;
                end
            end
            n_pos = '0;
        end else begin
            n_pos = (r_pos < MAX_FRAME_BYTES) ? r_pos + 12'd1 : MAX_FRAME_BYTES;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_hdr   <= '0;
            r_seg   <= '0;
            r_proto <= '0;
            r_frag  <= '0;
            r_src   <= '0;
            r_dst   <= '0;
        end else if (i_en) begin
            r_pos   <= n_pos;
            r_hdr   <= n_hdr;
            r_seg   <= n_seg;
            r_proto <= n_proto;
            r_frag  <= n_frag;
            r_src   <= n_src;
            r_dst   <= n_dst;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && r_pos >= POS_DST_FIRST && r_pos <= POS_DST_HELD) begin
            r_held[k_held] <= i_data_byte;
        end
    end

    always_comb begin
        for (int k = 0; k < RES_MAX; k++) begin
            o_res[k] = res[k];
        end
        o_cnt = cnt;
    end

endmodule

[src/ipv4nat_queue.sv]
// ----------------------------------------------------------------------------
// ipv4nat_queue
// Result queue: takes up to four items per cycle, flags busy when fewer than
// four slots are free, and hands out one per cycle over a valid/stall port.
// ----------------------------------------------------------------------------
module ipv4nat_queue
    import ipv4nat_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr_en,
    input  t_res                 i_res [RES_MAX],
    input  logic [RES_CNT_W-1:0] i_cnt,
    output logic                 o_busy,
    output logic                 o_valid,
    input  logic                 i_stall,
    output t_res                 o_res
);

    t_res               r_mem [Q_DEPTH];
    logic [Q_AW-1:0]    r_wp, n_wp;
    logic [Q_AW-1:0]    r_rp, n_rp;
    logic [Q_CNT_W-1:0] r_cnt, n_cnt;
    logic [Q_CNT_W-1:0] wr_n;
    logic               pop;

    assign o_valid = (r_cnt != '0);
    assign o_busy  = (r_cnt > Q_CNT_W'(Q_DEPTH - RES_MAX));
    assign o_res   = r_mem[r_rp];
    assign pop     = o_valid && !i_stall;
    assign wr_n    = i_wr_en ? Q_CNT_W'(i_cnt) : '0;

    always_comb begin
        n_wp  = r_wp + Q_AW'(wr_n);
        n_rp  = r_rp + Q_AW'(pop);
        n_cnt = r_cnt + wr_n - Q_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < RES_MAX; k++) begin
            if (i_wr_en && RES_CNT_W'(k) < i_cnt) begin
                r_mem[r_wp + Q_AW'(k)] <= i_res[k];
            end
        end
    end

endmodule

[src/ipv4_address_rewrite_checksum.sv]
// ----------------------------------------------------------------------------
// ipv4_address_rewrite_checksum
// Result items enter the result queue as their frame byte is taken;
// destination bytes 30..32 wait for byte 33, then leave one per cycle
// unless stalled. Throughput: one frame byte per cycle while o_stall is low.
// Reset: synchronous active-low, clears position, sums and the result queue.
// ----------------------------------------------------------------------------
module ipv4_address_rewrite_checksum
    import ipv4nat_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_frame_last,
    input  logic [31:0] i_new_source,
    input  logic [31:0] i_new_dest,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_out_last,
    output logic [15:0] o_ip_checksum,
    output logic [15:0] o_tcp_checksum,
    output logic        o_tcp_present,
    output logic        o_checksums_valid
);

    t_res                 core_res [RES_MAX];
    logic [RES_CNT_W-1:0] core_cnt;
    logic                 busy;
    logic                 accept;
    t_res                 head;

    assign o_stall = busy;
    assign accept  = i_valid && !busy;

    ipv4nat_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (accept),
        .i_data_byte  (i_data_byte),
        .i_frame_last (i_frame_last),
        .i_new_source (i_new_source),
        .i_new_dest   (i_new_dest),
        .o_res        (core_res),
        .o_cnt        (core_cnt)
    );

    ipv4nat_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (accept),
        .i_res   (core_res),
        .i_cnt   (core_cnt),
        .o_busy  (busy),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (head)
    );

    assign o_out_byte        = head.out_byte;
    assign o_out_last        = head.out_last;
    assign o_ip_checksum     = head.ip_checksum;
    assign o_tcp_checksum    = head.tcp_checksum;
    assign o_tcp_present     = head.tcp_present;
    assign o_checksums_valid = head.checksums_valid;

endmodule
